/* design/obn_pkg.sv */
// ----------------------------------------------------------------------------
// obn_pkg
// Shared widths and types for the orthonormal basis pipeline.
// ----------------------------------------------------------------------------
package obn_pkg;

   // fixed point format of the vector components
   localparam int FRAC_BITS = 14;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int COMP_W    = 16;
   localparam int EXT_W     = COMP_W + 1;

   // cross product components and their magnitudes
   localparam int CROSS_W = 34;
   localparam int MAG_W   = CROSS_W - 1;
   localparam int LEAD_W  = 6;

   // prescaled magnitudes keep their top bit at NORM_TOP
   localparam int NORM_TOP = 29;
   localparam int SCL_W    = NORM_TOP + 1;
   localparam int SQ_W     = 2 * SCL_W;
   localparam int SUM_W    = SQ_W + 2;

   // square root and divide pipelines
   localparam int ROOT_W     = SUM_W + 1;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int R_W        = ROOT_STEPS;
   localparam int QUO_W      = FRAC_BITS + 1;
   localparam int REM_W      = SCL_W + FRAC_BITS + 1;

   typedef logic [2:0][COMP_W-1:0]  vec_type;
   typedef logic [2:0][CROSS_W-1:0] cross_type;

   // data that rides along a normalizer unchanged
   typedef struct packed {
      vec_type n;
      vec_type t;
      logic    degen;
   } side_type;

endpackage

/* design/obn_norm.sv */
// ----------------------------------------------------------------------------
// obn_norm
// Pipelined vector normalizer: prescale, sum of squares, one square root
// step per stage, one quotient bit per stage, rounded to the fixed format.
// ----------------------------------------------------------------------------
module obn_norm import obn_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  cross_type in_vec,
   input  side_type  in_side,
   output logic      out_valid,
   output vec_type   out_vec,
   output logic      out_zero,
   output side_type  out_side
);

   typedef struct packed {
      logic [2:0][SCL_W-1:0] mag;
      logic [2:0]            neg;
      logic                  zero;
      side_type              side;
   } carry_type;

   typedef struct packed {
      carry_type         c;
      logic [ROOT_W-1:0] s;
      logic [ROOT_W-1:0] res;
   } root_type;

   typedef struct packed {
      carry_type                  c;
      logic [R_W-1:0]             r;
      logic [2:0][REM_W-1:0]      rem;
      logic [2:0][QUO_W-1:0]      quo;
   } div_type;

   // stage A: magnitudes and largest magnitude
   logic                  a_valid_ff;
   logic [2:0][MAG_W-1:0] a_mag_ff, a_mag_in;
   logic [2:0]            a_neg_ff, a_neg_in;
   logic [MAG_W-1:0]      a_max_ff, a_max_in;
   side_type              a_side_ff;

   always_comb begin
      a_max_in = '0;
      for (int i = 0; i < 3; i++) begin
         a_neg_in[i] = in_vec[i][CROSS_W-1];
         a_mag_in[i] = a_neg_in[i] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
         if (a_mag_in[i] > a_max_in) begin
            a_max_in = a_mag_in[i];
         end
      end
   end

   // stage B: leading one of the largest magnitude
   logic                  b_valid_ff;
   logic [2:0][MAG_W-1:0] b_mag_ff;
   logic [2:0]            b_neg_ff;
   logic [LEAD_W-1:0]     b_lead_ff, b_lead_in;
   logic                  b_zero_ff;
   side_type              b_side_ff;

   always_comb begin
      b_lead_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (a_max_ff[i]) begin
            b_lead_in = LEAD_W'(i);
         end
      end
   end

   // stage C: shift so the largest magnitude tops out at NORM_TOP
   logic      c_valid_ff;
   carry_type c_ff, c_in;

   always_comb begin
      c_in.neg  = b_neg_ff;
      c_in.zero = b_zero_ff;
      c_in.side = b_side_ff;
      for (int i = 0; i < 3; i++) begin
         if (b_lead_ff > LEAD_W'(NORM_TOP)) begin
            c_in.mag[i] = SCL_W'(b_mag_ff[i] >> (b_lead_ff - LEAD_W'(NORM_TOP)));
         end else begin
            c_in.mag[i] = SCL_W'(b_mag_ff[i] << (LEAD_W'(NORM_TOP) - b_lead_ff));
         end
      end
   end

   // stage D: squares
   logic                 d_valid_ff;
   carry_type            d_ff;
   logic [2:0][SQ_W-1:0] d_sq_ff, d_sq_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d_sq_in[i] = SQ_W'(c_ff.mag[i]) * SQ_W'(c_ff.mag[i]);
      end
   end

   // square root: stage 0 holds the sum, each later stage retires one bit pair
   logic     rt_valid_ff [ROOT_STEPS+1];
   root_type rt_ff       [ROOT_STEPS+1];
   root_type rt_in       [ROOT_STEPS+1];

   always_comb begin
      logic [ROOT_W-1:0] bitv;
      logic [ROOT_W-1:0] trial;
      rt_in[0].c   = d_ff;
      rt_in[0].s   = ROOT_W'(d_sq_ff[0]) + ROOT_W'(d_sq_ff[1]) + ROOT_W'(d_sq_ff[2]);
      rt_in[0].res = '0;
      for (int k = 0; k < ROOT_STEPS; k++) begin
         bitv          = ROOT_W'(1) << (SUM_W - 2 - 2 * k);
         trial         = rt_ff[k].res + bitv;
         rt_in[k+1].c  = rt_ff[k].c;
         if (rt_ff[k].s >= trial) begin
            rt_in[k+1].s   = rt_ff[k].s - trial;
            rt_in[k+1].res = (rt_ff[k].res >> 1) + bitv;
         end else begin
            rt_in[k+1].s   = rt_ff[k].s;
            rt_in[k+1].res = rt_ff[k].res >> 1;
         end
      end
   end

   // divide: stage 0 forms the rounded dividend, each later stage one quotient bit
   logic    dv_valid_ff [QUO_W+1];
   div_type dv_ff       [QUO_W+1];
   div_type dv_in       [QUO_W+1];

   always_comb begin
      logic [REM_W-1:0] dvs;
      dv_in[0].c   = rt_ff[ROOT_STEPS].c;
      dv_in[0].r   = R_W'(rt_ff[ROOT_STEPS].res);
      dv_in[0].quo = '0;
      for (int i = 0; i < 3; i++) begin
         dv_in[0].rem[i] = (REM_W'(rt_ff[ROOT_STEPS].c.mag[i]) << FRAC_BITS)
                         + REM_W'(dv_in[0].r >> 1);
      end
      for (int j = 0; j < QUO_W; j++) begin
         dv_in[j+1] = dv_ff[j];
         dvs        = REM_W'(dv_ff[j].r) << (QUO_W - 1 - j);
         for (int i = 0; i < 3; i++) begin
            if (dv_ff[j].rem[i] >= dvs) begin
               dv_in[j+1].rem[i]              = dv_ff[j].rem[i] - dvs;
               dv_in[j+1].quo[i][QUO_W-1-j]   = 1'b1;
            end
         end
      end
   end

   // output: apply signs, force zero for a zero vector
   vec_type out_vec_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_ff[QUO_W].c.zero) begin
            out_vec_in[i] = '0;
         end else if (dv_ff[QUO_W].c.neg[i]) begin
            out_vec_in[i] = -COMP_W'(dv_ff[QUO_W].quo[i]);
         end else begin
            out_vec_in[i] = COMP_W'(dv_ff[QUO_W].quo[i]);
         end
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         for (int k = 0; k <= ROOT_STEPS; k++) rt_valid_ff[k] <= 1'b0;
         for (int j = 0; j <= QUO_W; j++) dv_valid_ff[j] <= 1'b0;
         out_valid  <= 1'b0;
      end else if (en) begin
         a_valid_ff     <= in_valid;
         b_valid_ff     <= a_valid_ff;
         c_valid_ff     <= b_valid_ff;
         d_valid_ff     <= c_valid_ff;
         rt_valid_ff[0] <= d_valid_ff;
         for (int k = 0; k < ROOT_STEPS; k++) rt_valid_ff[k+1] <= rt_valid_ff[k];
         dv_valid_ff[0] <= rt_valid_ff[ROOT_STEPS];
         for (int j = 0; j < QUO_W; j++) dv_valid_ff[j+1] <= dv_valid_ff[j];
         out_valid      <= dv_valid_ff[QUO_W];
      end
   end

   // payload, advanced together with the valid bits
   always_ff @(posedge clock) begin
      if (en) begin
         a_mag_ff  <= a_mag_in;
         a_neg_ff  <= a_neg_in;
         a_max_ff  <= a_max_in;
         a_side_ff <= in_side;
         b_mag_ff  <= a_mag_ff;
         b_neg_ff  <= a_neg_ff;
         b_lead_ff <= b_lead_in;
         b_zero_ff <= (a_max_ff == '0);
         b_side_ff <= a_side_ff;
         c_ff      <= c_in;
         d_ff      <= c_ff;
         d_sq_ff   <= d_sq_in;
         for (int k = 0; k <= ROOT_STEPS; k++) rt_ff[k] <= rt_in[k];
         for (int j = 0; j <= QUO_W; j++) dv_ff[j] <= dv_in[j];
         out_vec   <= out_vec_in;
         out_zero  <= dv_ff[QUO_W].c.zero;
         out_side  <= dv_ff[QUO_W].c.side;
      end
   end

endmodule

/* design/orthonormal_basis_from_normal.sv */
// ----------------------------------------------------------------------------
// orthonormal_basis_from_normal
// Tangent, bitangent and normal of a Q1.14 unit normal as matrix columns.
// ----------------------------------------------------------------------------
// Accepts one normal per clock while the pipeline is not stalled and returns
// each basis in order. Two normalizers sit in series, each with a 31-stage
// square root and a 15-stage divider; the whole pipeline stalls as one while
// a result waits on rsp_stall. A normal whose tangent cross product is zero
// returns all zero columns with rsp_degenerate set.
module orthonormal_basis_from_normal import obn_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [COMP_W-1:0] req_n_x,
   input  logic signed [COMP_W-1:0] req_n_y,
   input  logic signed [COMP_W-1:0] req_n_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [COMP_W-1:0] rsp_tan_x,
   output logic signed [COMP_W-1:0] rsp_tan_y,
   output logic signed [COMP_W-1:0] rsp_tan_z,
   output logic signed [COMP_W-1:0] rsp_bit_x,
   output logic signed [COMP_W-1:0] rsp_bit_y,
   output logic signed [COMP_W-1:0] rsp_bit_z,
   output logic signed [COMP_W-1:0] rsp_col_n_x,
   output logic signed [COMP_W-1:0] rsp_col_n_y,
   output logic signed [COMP_W-1:0] rsp_col_n_z,
   output logic                     rsp_degenerate
);

   logic en;

   // advance everything unless a result waits on a stalled output
   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   // stage 1: capture the transfer
   logic    s1_valid_ff;
   vec_type s1_n_ff;

   // stage 2: helper vector and first cross product
   logic                      s2_valid_ff;
   vec_type                   s2_n_ff;
   cross_type                 s2_c_ff, s2_c_in;
   logic signed [EXT_W-1:0]   ns  [3];
   logic signed [EXT_W-1:0]   an  [3];
   logic signed [EXT_W-1:0]   q   [3];
   logic signed [CROSS_W-1:0] qe  [3];
   logic signed [CROSS_W-1:0] ne  [3];
   logic [1:0]                mi;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ns[i] = {s1_n_ff[i][COMP_W-1], s1_n_ff[i]};
         an[i] = ns[i][EXT_W-1] ? -ns[i] : ns[i];
         q[i]  = ns[i];
      end
      mi = 2'd0;
      if (an[1] < an[0]) mi = 2'd1;
      if (an[2] < an[mi]) mi = 2'd2;
      q[mi] = EXT_W'(ONE);
      for (int i = 0; i < 3; i++) begin
         qe[i] = CROSS_W'(q[i]);
         ne[i] = CROSS_W'(ns[i]);
      end
      s2_c_in[0] = qe[1] * ne[2] - qe[2] * ne[1];
      s2_c_in[1] = qe[2] * ne[0] - qe[0] * ne[2];
      s2_c_in[2] = qe[0] * ne[1] - qe[1] * ne[0];
   end

   // first normalizer: tangent
   side_type n1_side_in, n1_side;
   logic     n1_valid, n1_zero;
   vec_type  n1_vec;

   always_comb begin
      n1_side_in.n     = s2_n_ff;
      n1_side_in.t     = '0;
      n1_side_in.degen = 1'b0;
   end

   obn_norm u_norm_tan (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_vec    (s2_c_ff),
      .in_side   (n1_side_in),
      .out_valid (n1_valid),
      .out_vec   (n1_vec),
      .out_zero  (n1_zero),
      .out_side  (n1_side)
   );

   // stage 3: second cross product, normal by tangent
   logic                      s3_valid_ff;
   cross_type                 s3_c_ff, s3_c_in;
   side_type                  s3_side_ff, s3_side_in;
   logic signed [CROSS_W-1:0] me [3];
   logic signed [CROSS_W-1:0] te [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         me[i] = CROSS_W'($signed(n1_side.n[i]));
         te[i] = CROSS_W'($signed(n1_vec[i]));
      end
      s3_c_in[0]       = me[1] * te[2] - me[2] * te[1];
      s3_c_in[1]       = me[2] * te[0] - me[0] * te[2];
      s3_c_in[2]       = me[0] * te[1] - me[1] * te[0];
      s3_side_in.n     = n1_side.n;
      s3_side_in.t     = n1_vec;
      s3_side_in.degen = n1_zero;
   end

   // second normalizer: bitangent
   side_type n2_side;
   logic     n2_valid, n2_zero;
   vec_type  n2_vec;

   obn_norm u_norm_bit (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s3_valid_ff),
      .in_vec    (s3_c_ff),
      .in_side   (s3_side_ff),
      .out_valid (n2_valid),
      .out_vec   (n2_vec),
      .out_zero  (n2_zero),
      .out_side  (n2_side)
   );

   // output register: zero all columns on a degenerate tangent
   vec_type rsp_t_ff, rsp_b_ff, rsp_n_ff;
   logic    rsp_valid_ff, rsp_degen_ff;
   vec_type rsp_t_in, rsp_b_in, rsp_n_in;

   always_comb begin
      if (n2_side.degen) begin
         rsp_t_in = '0;
         rsp_b_in = '0;
         rsp_n_in = '0;
      end else begin
         rsp_t_in = n2_side.t;
         rsp_b_in = n2_zero ? '0 : n2_vec;
         rsp_n_in = n2_side.n;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= n1_valid;
         rsp_valid_ff <= n2_valid;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         s1_n_ff      <= {req_n_z, req_n_y, req_n_x};
         s2_n_ff      <= s1_n_ff;
         s2_c_ff      <= s2_c_in;
         s3_c_ff      <= s3_c_in;
         s3_side_ff   <= s3_side_in;
         rsp_t_ff     <= rsp_t_in;
         rsp_b_ff     <= rsp_b_in;
         rsp_n_ff     <= rsp_n_in;
         rsp_degen_ff <= n2_side.degen;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_tan_x      = rsp_t_ff[0];
   assign rsp_tan_y      = rsp_t_ff[1];
   assign rsp_tan_z      = rsp_t_ff[2];
   assign rsp_bit_x      = rsp_b_ff[0];
   assign rsp_bit_y      = rsp_b_ff[1];
   assign rsp_bit_z      = rsp_b_ff[2];
   assign rsp_col_n_x    = rsp_n_ff[0];
   assign rsp_col_n_y    = rsp_n_ff[1];
   assign rsp_col_n_z    = rsp_n_ff[2];
   assign rsp_degenerate = rsp_degen_ff;

endmodule
